### src/ctxpp_pkg.sv
// Shared types, constants and helpers for the context packet parser.
// No dependencies; imported by every module of the block.
package ctxpp_pkg;

  localparam int FIELD_COUNT = 6;
  localparam logic [2:0] CURSOR_DONE = 3'd6;

  // field order: bandwidth, rf, ref level, gain, sample rate, state/event
  localparam logic [FIELD_COUNT-1:0] TWO_WORD = 6'b010011;

  localparam logic [2:0] FLD_BANDWIDTH = 3'd0;
  localparam logic [2:0] FLD_RF        = 3'd1;
  localparam logic [2:0] FLD_REF_LEVEL = 3'd2;
  localparam logic [2:0] FLD_GAIN      = 3'd3;
  localparam logic [2:0] FLD_SAMPLE    = 3'd4;
  localparam logic [2:0] FLD_STATE     = 3'd5;

  localparam logic [1:0] REG_OUI   = 2'd0;
  localparam logic [1:0] REG_CLASS = 2'd1;
  localparam logic [1:0] REG_TYPE  = 2'd2;

  localparam logic [3:0] TYPE_RESET = 4'd4;

  typedef struct packed {
    logic [23:0] oui;
    logic [15:0] pkt_class;
    logic [3:0]  type_code;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  packet_type;
    logic        class_present;
    logic [23:0] class_oui;
    logic [15:0] class_code;
    logic        word_present;
    logic [31:0] payload_word;
    logic        first_item;
    logic        last_item;
  } in_beat_t;

  typedef struct packed {
    logic        parse_ok;
    logic [5:0]  present_mask;
    logic [63:0] bandwidth_raw;
    logic [63:0] rf_frequency_raw;
    logic [15:0] reference_level_raw;
    logic [15:0] gain_raw;
    logic [63:0] sample_rate_raw;
    logic [31:0] state_event_word;
  } rec_t;

  // CIF0 presence flags in field order
  function automatic logic [FIELD_COUNT-1:0] cif_flags(input logic [31:0] bm);
    cif_flags = {bm[19], bm[21], bm[23], bm[24], bm[27], bm[29]};
  endfunction

  // first flagged field at or after start, CURSOR_DONE if none
  function automatic logic [2:0] first_present(input logic [FIELD_COUNT-1:0] flags,
                                               input logic [2:0] start);
    logic [2:0] res;
    logic       found;
    res   = CURSOR_DONE;
    found = 1'b0;
    for (int i = 0; i < FIELD_COUNT; i++) begin
      if (!found && flags[i] && (3'(i) >= start)) begin
        res   = 3'(i);
        found = 1'b1;
      end
    end
    first_present = res;
  endfunction

endpackage

### src/ctxpp_cfg.sv
// Configuration register file of the context packet parser.
// Depends on ctxpp_pkg (cfg_t, register index codes).
module ctxpp_cfg import ctxpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [23:0] wr_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.oui       <= '0;
      cfg_r.pkt_class <= '0;
      cfg_r.type_code <= TYPE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_OUI:   cfg_r.oui       <= wr_data;
        REG_CLASS: cfg_r.pkt_class <= wr_data[15:0];
        REG_TYPE:  cfg_r.type_code <= wr_data[3:0];
        default:   ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### src/ctxpp_core.sv
// Parser datapath: input beat register, per-packet state, result register.
// Depends on ctxpp_pkg (beat and record types, field decode helpers).
module ctxpp_core import ctxpp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_beat,
  output logic     out_valid,
  input  logic     out_ready,
  output rec_t     out_rec
);

  logic     s1_valid_r;
  in_beat_t s1_r;
  logic     advance;

  logic              hdr_r, hdr_nxt;
  logic              seen_r, seen_nxt;
  logic [31:0]       bm_r, bm_nxt;
  logic [2:0]        cur_r, cur_nxt;
  logic              uhd_r, uhd_nxt;
  logic [31:0]       uh_r, uh_nxt;
  logic [5:0]        fm_r, fm_nxt;
  logic [63:0]       bw_r, bw_nxt;
  logic [63:0]       rf_r, rf_nxt;
  logic [15:0]       rl_r, rl_nxt;
  logic [15:0]       gn_r, gn_nxt;
  logic [63:0]       sr_r, sr_nxt;
  logic [31:0]       se_r, se_nxt;

  logic              out_valid_r;
  rec_t              rec_r, rec_nxt;
  logic              ok;
  logic [5:0]        flags;
  logic [31:0]       w;

  // a beat without last never needs the result slot
  assign advance  = s1_valid_r && (!s1_r.last_item || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_beat;
    end
  end

  always_comb begin
    w        = s1_r.payload_word;
    hdr_nxt  = hdr_r;
    seen_nxt = seen_r;
    bm_nxt   = bm_r;
    cur_nxt  = cur_r;
    uhd_nxt  = uhd_r;
    uh_nxt   = uh_r;
    fm_nxt   = fm_r;
    bw_nxt   = bw_r;
    rf_nxt   = rf_r;
    rl_nxt   = rl_r;
    gn_nxt   = gn_r;
    sr_nxt   = sr_r;
    se_nxt   = se_r;

    if (s1_r.first_item) begin
      hdr_nxt  = (s1_r.packet_type == cfg.type_code) && s1_r.class_present &&
                 (s1_r.class_oui == cfg.oui) && (s1_r.class_code == cfg.pkt_class);
      seen_nxt = 1'b0;
      bm_nxt   = '0;
      cur_nxt  = '0;
      uhd_nxt  = 1'b0;
      uh_nxt   = '0;
      fm_nxt   = '0;
    end

    if (s1_r.word_present) begin
      if (!seen_nxt) begin
        bm_nxt   = w;
        seen_nxt = 1'b1;
        cur_nxt  = first_present(cif_flags(w), 3'd0);
      end else if (cur_nxt < CURSOR_DONE) begin
        if (TWO_WORD[cur_nxt] && !uhd_nxt) begin
          uh_nxt  = w;
          uhd_nxt = 1'b1;
        end else begin
          uhd_nxt = 1'b0;
          case (cur_nxt)
            FLD_BANDWIDTH: bw_nxt = {uh_nxt, w};
            FLD_RF:        rf_nxt = {uh_nxt, w};
            FLD_REF_LEVEL: rl_nxt = w[15:0];
            FLD_GAIN:      gn_nxt = w[15:0];
            FLD_SAMPLE:    sr_nxt = {uh_nxt, w};
            default:       se_nxt = w;
          endcase
          fm_nxt[cur_nxt] = 1'b1;
          cur_nxt = first_present(cif_flags(bm_nxt), cur_nxt + 3'd1);
        end
      end
    end
  end

  assign flags = cif_flags(bm_nxt);
  assign ok    = hdr_nxt && seen_nxt && (cur_nxt == CURSOR_DONE) && (fm_nxt == flags);

  // held values are only meaningful where the filled bit is set
  always_comb begin
    rec_nxt                     = '0;
    if (ok) begin
      rec_nxt.parse_ok            = 1'b1;
      rec_nxt.present_mask        = fm_nxt;
      rec_nxt.bandwidth_raw       = fm_nxt[FLD_BANDWIDTH] ? bw_nxt : '0;
      rec_nxt.rf_frequency_raw    = fm_nxt[FLD_RF]        ? rf_nxt : '0;
      rec_nxt.reference_level_raw = fm_nxt[FLD_REF_LEVEL] ? rl_nxt : '0;
      rec_nxt.gain_raw            = fm_nxt[FLD_GAIN]      ? gn_nxt : '0;
      rec_nxt.sample_rate_raw     = fm_nxt[FLD_SAMPLE]    ? sr_nxt : '0;
      rec_nxt.state_event_word    = fm_nxt[FLD_STATE]     ? se_nxt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r  <= 1'b0;
      seen_r <= 1'b0;
      bm_r   <= '0;
      cur_r  <= '0;
      uhd_r  <= 1'b0;
      fm_r   <= '0;
    end else if (advance) begin
      hdr_r  <= hdr_nxt;
      seen_r <= seen_nxt;
      bm_r   <= bm_nxt;
      cur_r  <= cur_nxt;
      uhd_r  <= uhd_nxt;
      fm_r   <= fm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      uh_r <= uh_nxt;
      bw_r <= bw_nxt;
      rf_r <= rf_nxt;
      rl_r <= rl_nxt;
      gn_r <= gn_nxt;
      sr_r <= sr_nxt;
      se_r <= se_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_r.last_item) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_r.last_item) begin
      rec_r <= rec_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rec   = rec_r;

endmodule

### src/context_packet_parser_top.sv
// Top level of the context packet parser: stream ports, packing, config port.
// Depends on ctxpp_pkg, ctxpp_cfg and ctxpp_core.
//
// Parses the payload words of a header-split VITA-49 IF context packet: the
// first word is the CIF0 bitmap, the flagged bandwidth, RF frequency,
// reference level, gain, sample rate and state/event fields follow in bit
// order. One record leaves per beat with tlast set. Throughput is one beat
// per clock while no record is held up; a last beat passes the input register
// and then the record register before its record is presented. A beat with
// tlast waits in the input register, and holds off the next beat, while the
// previous record is still waiting for out_tready. The config port is always
// ready. Write it only while the parser is idle; the block does not enforce it.
module context_packet_parser_top import ctxpp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // packet_type, class_present, class_oui, class_code, payload_word, zero pad
  input  logic [79:0]  in_tdata,
  // word_present, first_item
  input  logic [1:0]   in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // parse_ok, present_mask, bandwidth_raw, rf_frequency_raw,
  // reference_level_raw, gain_raw, sample_rate_raw, state_event_word, zero pad
  output logic [263:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  cfg_t     cfg;
  in_beat_t beat;
  rec_t     rec;

  assign cfg_ready = 1'b1;

  ctxpp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign beat.packet_type   = in_tdata[3:0];
  assign beat.class_present = in_tdata[4];
  assign beat.class_oui     = in_tdata[28:5];
  assign beat.class_code    = in_tdata[44:29];
  assign beat.payload_word  = in_tdata[76:45];
  assign beat.word_present  = in_tuser[0];
  assign beat.first_item    = in_tuser[1];
  assign beat.last_item     = in_tlast;

  ctxpp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_beat   (beat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rec   (rec)
  );

  assign out_tdata = {1'b0,
                      rec.state_event_word,
                      rec.sample_rate_raw,
                      rec.gain_raw,
                      rec.reference_level_raw,
                      rec.rf_frequency_raw,
                      rec.bandwidth_raw,
                      rec.present_mask,
                      rec.parse_ok};

endmodule
